// File: sv/multicore_tile_partitioner_macros.svh
// Assertion macros used by the checker file.
`ifndef MULTICORE_TILE_PARTITIONER_MACROS_SVH
`define MULTICORE_TILE_PARTITIONER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define MTP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("multicore_tile_partitioner: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define MTP_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("multicore_tile_partitioner: same-cycle check failed");

`endif

// File: sv/mtp_pkg.sv
package mtp_pkg;

  localparam int ALIGN_ELEMS    = 16;
  localparam int ALIGN_SHIFT    = $clog2(ALIGN_ELEMS);
  localparam int TILE_BLOCKS    = 256;
  localparam int TILE_SHIFT     = $clog2(TILE_BLOCKS);
  localparam int BLK_W          = 28;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = BLK_W / BITS_PER_STAGE;

  typedef struct packed {
    logic             valid;
    logic [7:0]       cores;
    logic [7:0]       rem;
    logic [BLK_W-1:0] dvd;
  } div_t;

endpackage

// File: sv/mtp_front.sv
module mtp_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_take,
  input  logic [30:0] element_count,
  input  logic [7:0]  cores_avail,
  output mtp_pkg::div_t stage_o
);

  logic [31:0]               sum_c;
  logic [mtp_pkg::BLK_W-1:0] blocks_c;
  logic [mtp_pkg::BLK_W:0]   need_sum_c;
  logic [20:0]               need_c;
  logic [7:0]                avail_c;
  logic [7:0]                cores_c;
  mtp_pkg::div_t             stage_r;
  mtp_pkg::div_t             stage_nxt;

  always_comb begin
    sum_c      = {1'b0, element_count} + 32'(mtp_pkg::ALIGN_ELEMS - 1);
    blocks_c   = sum_c[31:mtp_pkg::ALIGN_SHIFT];
    need_sum_c = {1'b0, blocks_c} + 29'(mtp_pkg::TILE_BLOCKS - 1);
    need_c     = need_sum_c[mtp_pkg::BLK_W:mtp_pkg::TILE_SHIFT];
    avail_c    = (cores_avail == 8'd0) ? 8'd1 : cores_avail;
    if (blocks_c <= 28'(mtp_pkg::TILE_BLOCKS)) begin
      cores_c = 8'd1;
    end else if (need_c <= {13'd0, avail_c}) begin
      cores_c = need_c[7:0];
    end else begin
      cores_c = avail_c;
    end
    stage_nxt.valid = in_take;
    stage_nxt.cores = cores_c;
    stage_nxt.rem   = 8'd0;
    stage_nxt.dvd   = blocks_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (adv) begin
      stage_r.cores <= stage_nxt.cores;
      stage_r.rem   <= stage_nxt.rem;
      stage_r.dvd   <= stage_nxt.dvd;
    end
  end

  assign stage_o = stage_r;

endmodule

// File: sv/mtp_div_stage.sv
module mtp_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  mtp_pkg::div_t stage_i,
  output mtp_pkg::div_t stage_o
);

  mtp_pkg::div_t stage_r;
  mtp_pkg::div_t stage_nxt;
  logic [8:0]    trial_c;

  always_comb begin
    stage_nxt = stage_i;
    trial_c   = 9'd0;
    for (int i = 0; i < mtp_pkg::BITS_PER_STAGE; i++) begin
      trial_c = {stage_nxt.rem, stage_nxt.dvd[mtp_pkg::BLK_W-1]};
      if (trial_c >= {1'b0, stage_nxt.cores}) begin
        trial_c = trial_c - {1'b0, stage_nxt.cores};
        stage_nxt.dvd = {stage_nxt.dvd[mtp_pkg::BLK_W-2:0], 1'b1};
      end else begin
        stage_nxt.dvd = {stage_nxt.dvd[mtp_pkg::BLK_W-2:0], 1'b0};
      end
      stage_nxt.rem = trial_c[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (adv) begin
      stage_r.cores <= stage_nxt.cores;
      stage_r.rem   <= stage_nxt.rem;
      stage_r.dvd   <= stage_nxt.dvd;
    end
  end

  assign stage_o = stage_r;

endmodule

// File: sv/mtp_out.sv
module mtp_out (
  input  logic          clk,
  input  logic          rst_n,
  input  mtp_pkg::div_t stage_i,
  output logic          stall,
  output logic          out_strobe,
  output logic          out_split_mode,
  output logic [7:0]    out_cores_used,
  output logic [7:0]    out_group_cores,
  output logic [31:0]   out_core_length,
  output logic [20:0]   out_tile_count,
  output logic [12:0]   out_tile_elems,
  output logic [12:0]   out_final_tile_elems,
  output logic          out_is_last
);

  logic                      phase_r;
  logic                      phase_nxt;
  logic                      split_c;
  logic [mtp_pkg::BLK_W-1:0] blk_c;
  logic [19:0]               n_c;
  logic [7:0]                part_c;
  logic [8:0]                even_c;
  logic [20:0]               cnt_c;
  logic [12:0]               tlen_c;
  logic [12:0]               last_c;
  logic [7:0]                group_c;
  logic                      strobe_r;
  logic                      split_r;
  logic [7:0]                used_r;
  logic [7:0]                group_r;
  logic [31:0]               len_r;
  logic [20:0]               cnt_r;
  logic [12:0]               tlen_r;
  logic [12:0]               last_r;
  logic                      last_flag_r;

  always_comb begin
    split_c   = stage_i.rem != 8'd0;
    stall     = stage_i.valid && split_c && !phase_r;
    phase_nxt = stall;
    if (split_c && !phase_r) begin
      blk_c   = stage_i.dvd + 28'd1;
      group_c = stage_i.rem;
    end else if (split_c) begin
      blk_c   = stage_i.dvd;
      group_c = stage_i.cores - stage_i.rem;
    end else begin
      blk_c   = stage_i.dvd;
      group_c = stage_i.cores;
    end
    n_c    = blk_c[mtp_pkg::BLK_W-1:mtp_pkg::TILE_SHIFT];
    part_c = blk_c[mtp_pkg::TILE_SHIFT-1:0];
    even_c = ({1'b0, part_c} + 9'd1) & 9'h1FE;
    if (part_c == 8'd0 || n_c == 20'd0) begin
      cnt_c  = (n_c == 20'd0) ? 21'd1 : {1'b0, n_c};
      tlen_c = (n_c == 20'd0) ? {even_c, 4'b0} : 13'(mtp_pkg::TILE_BLOCKS
               * mtp_pkg::ALIGN_ELEMS);
      last_c = tlen_c;
    end else begin
      cnt_c  = {1'b0, n_c} + 21'd1;
      tlen_c = 13'(mtp_pkg::TILE_BLOCKS * mtp_pkg::ALIGN_ELEMS);
      last_c = {1'b0, part_c, 4'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      strobe_r <= stage_i.valid;
    end
    split_r     <= split_c;
    used_r      <= stage_i.cores;
    group_r     <= group_c;
    len_r       <= {blk_c, 4'b0};
    cnt_r       <= cnt_c;
    tlen_r      <= tlen_c;
    last_r      <= last_c;
    last_flag_r <= !stall;
  end

  assign out_strobe           = strobe_r;
  assign out_split_mode       = split_r;
  assign out_cores_used       = used_r;
  assign out_group_cores      = group_r;
  assign out_core_length      = len_r;
  assign out_tile_count       = cnt_r;
  assign out_tile_elems       = tlen_r;
  assign out_final_tile_elems = last_r;
  assign out_is_last          = last_flag_r;

endmodule

// File: sv/multicore_tile_partitioner.sv
// Channel  Handshake              Payload
// in       start, busy            in_element_count
// out      out_strobe             split_mode, cores, lengths, tiles, is_last
// cfg      cfg_valid, cfg_ready   cfg_cores_available
//
// An item passes one front stage, seven divider stages (four quotient bits
// each) and one output stage, each of them registered. Even splits sustain one
// item per cycle; a head and tail split holds the pipeline, with busy high,
// while the output stage registers the head result ahead of the tail result.
// Reset is synchronous and active low; it empties the pipeline and sets the
// core limit to eight. Results cannot be stalled by the receiver.
module multicore_tile_partitioner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] in_element_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_cores_available,
  output logic        out_strobe,
  output logic        out_split_mode,
  output logic [7:0]  out_cores_used,
  output logic [7:0]  out_group_cores,
  output logic [31:0] out_core_length,
  output logic [20:0] out_tile_count,
  output logic [12:0] out_tile_elems,
  output logic [12:0] out_final_tile_elems,
  output logic        out_is_last
);

  logic          stall;
  logic          adv;
  logic [7:0]    cores_avail_r;
  mtp_pkg::div_t stages [mtp_pkg::DIV_STAGES+1];

  assign adv       = !stall;
  assign busy      = stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cores_avail_r <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      cores_avail_r <= cfg_cores_available;
    end
  end

  mtp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_take       (start && !busy),
    .element_count (in_element_count),
    .cores_avail   (cores_avail_r),
    .stage_o       (stages[0])
  );

  for (genvar g = 0; g < mtp_pkg::DIV_STAGES; g++) begin : g_div
    mtp_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (stages[g]),
      .stage_o (stages[g+1])
    );
  end

  mtp_out u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .stage_i              (stages[mtp_pkg::DIV_STAGES]),
    .stall                (stall),
    .out_strobe           (out_strobe),
    .out_split_mode       (out_split_mode),
    .out_cores_used       (out_cores_used),
    .out_group_cores      (out_group_cores),
    .out_core_length      (out_core_length),
    .out_tile_count       (out_tile_count),
    .out_tile_elems       (out_tile_elems),
    .out_final_tile_elems (out_final_tile_elems),
    .out_is_last          (out_is_last)
  );

endmodule

// File: sv/mtp_checker.sv
`include "multicore_tile_partitioner_macros.svh"

module mtp_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_strobe,
  input logic out_is_last,
  input logic out_split_mode
);

  `MTP_ASSERT_NEXT(head_then_tail, out_strobe && !out_is_last, out_strobe && out_is_last)
  `MTP_ASSERT_NEXT(busy_one_cycle, busy, !busy)
  `MTP_ASSERT_SAME(head_is_split, out_strobe && !out_is_last, out_split_mode)
  `MTP_ASSERT_NEXT(busy_gives_head, busy, out_strobe && !out_is_last)

endmodule

bind multicore_tile_partitioner mtp_checker u_mtp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_is_last    (out_is_last),
  .out_split_mode (out_split_mode)
);

// File: verif/multicore_tile_partitioner_tb.sv
`timescale 1ns / 1ps

module multicore_tile_partitioner_tb;

  localparam logic SPLIT_EVEN      = 1'b0;
  localparam logic SPLIT_HEAD_TAIL = 1'b1;
  localparam longint unsigned BLOCK_ELEMS = 16;
  localparam longint unsigned TILE_ELEMS  = 256 * 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic        split_mode;
    logic [7:0]  cores_used;
    logic [7:0]  group_cores;
    logic [31:0] core_length;
    logic [20:0] tile_count;
    logic [12:0] tile_elems;
    logic [12:0] final_tile_elems;
    logic        is_last;
  } plan_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [30:0] in_element_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_cores_available;
  logic        out_strobe;
  logic        out_split_mode;
  logic [7:0]  out_cores_used;
  logic [7:0]  out_group_cores;
  logic [31:0] out_core_length;
  logic [20:0] out_tile_count;
  logic [12:0] out_tile_elems;
  logic [12:0] out_final_tile_elems;
  logic        out_is_last;

  logic [30:0] pending_counts[$];
  plan_t       expected_plans[$];
  logic [7:0]  cores_limit;
  int          sender_idle_pct;
  bit          sender_hold;
  int          mismatches;
  int          cycles;

  multicore_tile_partitioner dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_element_count(in_element_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_cores_available(cfg_cores_available),
    .out_strobe(out_strobe), .out_split_mode(out_split_mode),
    .out_cores_used(out_cores_used), .out_group_cores(out_group_cores),
    .out_core_length(out_core_length), .out_tile_count(out_tile_count),
    .out_tile_elems(out_tile_elems),
    .out_final_tile_elems(out_final_tile_elems), .out_is_last(out_is_last)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic plan_t group_plan(logic mode, longint unsigned used,
                                       longint unsigned group, longint unsigned len,
                                       logic last);
    longint unsigned blocks, tiles, tlen, tlast;
    plan_t p;
    blocks = len / BLOCK_ELEMS;
    tiles = blocks / 256;
    if (blocks % 256 == 0 || tiles == 0) begin
      if (tiles == 0) tiles = 1;
      tlen = (len < TILE_ELEMS) ? (blocks + 1) / 2 * 2 * BLOCK_ELEMS : TILE_ELEMS;
      tlast = tlen;
    end else begin
      tiles = tiles + 1;
      tlen = TILE_ELEMS;
      tlast = len - (tiles - 1) * TILE_ELEMS;
    end
    p.split_mode = mode;
    p.cores_used = used[7:0];
    p.group_cores = group[7:0];
    p.core_length = len[31:0];
    p.tile_count = tiles[20:0];
    p.tile_elems = tlen[12:0];
    p.final_tile_elems = tlast[12:0];
    p.is_last = last;
    return p;
  endfunction

  task automatic predict_split(logic [30:0] count);
    longint unsigned aligned, blocks, avail, need, cores, head, head_len, tail_len;
    aligned = (longint'(count) + BLOCK_ELEMS - 1) / BLOCK_ELEMS * BLOCK_ELEMS;
    blocks = aligned / BLOCK_ELEMS;
    avail = (cores_limit == 0) ? 1 : cores_limit;
    if (aligned <= TILE_ELEMS) begin
      cores = 1;
    end else begin
      need = blocks / 256 + ((blocks % 256 != 0) ? 1 : 0);
      cores = (need <= avail) ? need : avail;
    end
    if (blocks % cores == 0) begin
      expected_plans.push_back(group_plan(SPLIT_EVEN, cores, cores, aligned / cores, 1'b1));
    end else begin
      head = blocks % cores;
      head_len = ((aligned + cores - 1) / cores + BLOCK_ELEMS - 1) / BLOCK_ELEMS
                 * BLOCK_ELEMS;
      tail_len = aligned / cores / BLOCK_ELEMS * BLOCK_ELEMS;
      expected_plans.push_back(group_plan(SPLIT_HEAD_TAIL, cores, head, head_len, 1'b0));
      expected_plans.push_back(group_plan(SPLIT_HEAD_TAIL, cores, cores - head,
                                          tail_len, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_element_count <= '0;
    end else begin
      if (start && !busy) begin
        predict_split(in_element_count);
        void'(pending_counts.pop_front());
      end
      if (start && busy) begin
      end else if (pending_counts.size() > 0 && !sender_hold &&
                   $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_element_count <= pending_counts[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    plan_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_split_mode, out_cores_used, out_group_cores, out_core_length,
             out_tile_count, out_tile_elems, out_final_tile_elems, out_is_last};
      if (expected_plans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = expected_plans.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    // Both queues are empty only once every accepted item has left the pipeline.
    while (pending_counts.size() > 0 || start || expected_plans.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cores(logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_cores_available <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cores_limit = value;
  endtask

  function automatic logic [30:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return 31'($urandom_range(0, 70000));
    if (pick < 65) return 31'($urandom_range(0, 2200000));
    if (pick < 80) return 31'($urandom_range(0, 1 << 20) * 16);
    return 31'($urandom);
  endfunction

  task automatic run_random(int n);
    repeat (n) pending_counts.push_back(random_count());
  endtask

  initial begin
    logic [30:0] directed[$];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_cores_available = '0;
    cores_limit = 8'd8;
    sender_idle_pct = 14;
    sender_hold = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cores(8'd8);
    directed = '{0, 1, 15, 16, 17, 4095, 4096, 4097, 4112, 8192, 8208, 12288,
                 32768, 32784, 36864, 40000, 1000000, 31'h7fffffff, 31'h7ffffff0,
                 31'h40000000, 31'h2aaaaaaa, 31'h55555555};
    foreach (directed[i]) pending_counts.push_back(directed[i]);
    run_random(250);
    write_cores(8'd1);
    foreach (directed[i]) pending_counts.push_back(directed[i]);
    run_random(200);
    write_cores(8'd255);
    foreach (directed[i]) pending_counts.push_back(directed[i]);
    run_random(250);
    sender_idle_pct = 59;
    write_cores(8'd0);
    run_random(150);
    write_cores(8'd7);
    run_random(250);
    sender_idle_pct = 0;
    write_cores(8'($urandom_range(2, 254)));
    run_random(250);
    write_cores(8'($urandom_range(1, 255)));
    run_random(300);
    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
